/* hw/rtl/pdbv_pkg.sv */
// Shared constants, types and the arctangent table of the pose differencing velocity block.
package pdbv_pkg;

  // default field widths
  localparam int POSITION_WIDTH_DEF = 32;
  localparam int HEADING_WIDTH_DEF  = 16;
  localparam int TIME_W             = 32;
  localparam int VEL_W              = 32;

  // rotation unit sizing: Q4.30 vector, Q16 angle
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 34;
  localparam int Z_W          = 21;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [Z_W-1:0]  PI_Q16          = 21'sd205887;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q16     = 21'sd102944;

  // saturation limits of a velocity word
  localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

  // divider request and status
  typedef struct packed {
    logic start;
    logic linear;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // arctangent of 2^-i in Q16 radians
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      4'd0:  v = 21'sd51472;
      4'd1:  v = 21'sd30385;
      4'd2:  v = 21'sd16055;
      4'd3:  v = 21'sd8150;
      4'd4:  v = 21'sd4091;
      4'd5:  v = 21'sd2047;
      4'd6:  v = 21'sd1024;
      4'd7:  v = 21'sd512;
      4'd8:  v = 21'sd256;
      4'd9:  v = 21'sd128;
      4'd10: v = 21'sd64;
      4'd11: v = 21'sd32;
      4'd12: v = 21'sd16;
      4'd13: v = 21'sd8;
      4'd14: v = 21'sd4;
      4'd15: v = 21'sd2;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/pdbv_in_if.sv */
// Pose sample channel: valid, ready and one pose word.
interface pdbv_in_if #(
  parameter int POSITION_WIDTH = pdbv_pkg::POSITION_WIDTH_DEF,
  parameter int HEADING_WIDTH  = pdbv_pkg::HEADING_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [POSITION_WIDTH-1:0]  pos_x;
  logic signed [POSITION_WIDTH-1:0]  pos_y;
  logic signed [HEADING_WIDTH-1:0]   heading;
  logic [pdbv_pkg::TIME_W-1:0]       timestamp;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output timestamp, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading,
                  input timestamp, output ready);
endinterface

/* hw/rtl/pdbv_out_if.sv */
// Velocity result channel: valid, ready and one velocity word.
interface pdbv_out_if;
  logic                              valid;
  logic                              ready;
  logic                              velocity_valid;
  logic signed [pdbv_pkg::VEL_W-1:0] vel_forward;
  logic signed [pdbv_pkg::VEL_W-1:0] vel_lateral;
  logic signed [pdbv_pkg::VEL_W-1:0] vel_turn;
  logic                              zero_interval;

  modport source (output valid, output velocity_valid, output vel_forward,
                  output vel_lateral, output vel_turn, output zero_interval,
                  input ready);
  modport sink   (input valid, input velocity_valid, input vel_forward,
                  input vel_lateral, input vel_turn, input zero_interval,
                  output ready);
endinterface

/* hw/rtl/pose_difference_body_velocity_top.sv */
// Body frame velocity from the difference of two successive planar pose samples.
// A first sample goes straight to the done state and gives a word marked invalid; a divide
// that overflows 32 bits or meets a zero interval skips its serial run. A new pose word is
// taken only after the previous word has been loaded into the output register, as the 16
// shared rotation steps, a shared multiplier pass and three serial divides work one sample.
// Reset: synchronous active-low rst_n clears the previous sample, the sequencer and valid.
module pose_difference_body_velocity_top #(
  parameter int POSITION_WIDTH = pdbv_pkg::POSITION_WIDTH_DEF,
  parameter int HEADING_WIDTH  = pdbv_pkg::HEADING_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pdbv_in_if.sink    in_if,
  pdbv_out_if.source out_if
);

  localparam int XY_W       = pdbv_pkg::XY_W;
  localparam int Z_W        = pdbv_pkg::Z_W;
  localparam int STEP_W     = pdbv_pkg::STEP_W;
  localparam int TIME_W     = pdbv_pkg::TIME_W;
  localparam int VEL_W      = pdbv_pkg::VEL_W;
  localparam int TRIG_FRAC  = ((56 - POSITION_WIDTH) > 30) ? 30 : (56 - POSITION_WIDTH);
  localparam int C_W        = TRIG_FRAC + 2;
  localparam int D_W        = POSITION_WIDTH + 1;
  localparam int H_D_W      = HEADING_WIDTH + 1;
  localparam int PROD_W     = D_W + C_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int NT_SH      = 35 - HEADING_WIDTH;
  localparam int RND        = 30 - TRIG_FRAC;
  localparam int LIN_SHIFT  = (TRIG_FRAC >= 16) ? (TRIG_FRAC - 16) : 0;
  localparam int POST_SHIFT = (TRIG_FRAC < 16) ? (16 - TRIG_FRAC) : 0;
  localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(pdbv_pkg::CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] MUL_LAST    = STEP_W'(4);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CORDIC  = 7'b0000010,
    S_ROUND   = 7'b0000100,
    S_MUL     = 7'b0001000,
    S_DIVGO   = 7'b0010000,
    S_DIVWAIT = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    DIV_FWD  = 2'd0,
    DIV_LAT  = 2'd1,
    DIV_TURN = 2'd2
  } div_sel_t;

  state_t                          state_r, state_nxt;
  logic [STEP_W-1:0]               cnt_r, cnt_nxt;

  logic                            have_prev_r;
  logic signed [POSITION_WIDTH-1:0] prev_x_r, prev_y_r;
  logic signed [HEADING_WIDTH-1:0] prev_h_r;
  logic [TIME_W-1:0]               prev_t_r;

  logic signed [D_W-1:0]           dx_r, dy_r;
  logic signed [H_D_W-1:0]         dh_r;
  logic [TIME_W-1:0]               dt_r;
  logic signed [XY_W-1:0]          x_r, y_r;
  logic signed [Z_W-1:0]           z_r;
  logic                            flip_r;
  logic signed [C_W-1:0]           c_r, s_r;
  logic signed [PROD_W-1:0]        prod_r;
  logic signed [NUM_W-1:0]         nf_r, nl_r;
  div_sel_t                        div_idx_r;

  logic                            vv_r, zi_r;
  logic [VEL_W-1:0]                res_fwd_r, res_lat_r, res_turn_r;

  logic                            out_valid_r, out_vv_r, out_zi_r;
  logic [VEL_W-1:0]                out_fwd_r, out_lat_r, out_turn_r;

  logic                            accept_w, out_take_w, out_load_w;
  logic signed [D_W-1:0]           dx_w, dy_w;
  logic signed [H_D_W-1:0]         dh_w;
  logic [TIME_W-1:0]               dt_w;
  logic signed [Z_W-1:0]           ang_w, z_fold_w, atan_w;
  logic                            flip_w;
  logic signed [XY_W-1:0]          sx_w, sy_w, vx_w, vy_w;
  logic signed [C_W-1:0]           c_w, s_w;
  logic signed [D_W-1:0]           mul_a_w;
  logic signed [C_W-1:0]           mul_b_w;
  logic signed [PROD_W-1:0]        prod_w;
  logic signed [NUM_W-1:0]         nt_w, div_num_w;
  pdbv_pkg::div_ctl_t              div_ctl;
  pdbv_pkg::div_stat_t             div_stat;
  logic [VEL_W-1:0]                div_res;

  // handshakes
  assign in_if.ready = (state_r == S_IDLE);
  assign accept_w    = in_if.valid && in_if.ready;
  assign out_take_w  = !out_valid_r || out_if.ready;
  assign out_load_w  = (state_r == S_DONE) && out_take_w;

  // differences against the stored sample
  assign dx_w = D_W'(in_if.pos_x) - D_W'(prev_x_r);
  assign dy_w = D_W'(in_if.pos_y) - D_W'(prev_y_r);
  assign dh_w = H_D_W'(in_if.heading) - H_D_W'(prev_h_r);
  assign dt_w = in_if.timestamp - prev_t_r;

  // move the heading to 16 fraction bits
  generate
    if (HEADING_WIDTH <= 19) begin : g_ang_up
      assign ang_w = Z_W'(in_if.heading) <<< (19 - HEADING_WIDTH);
    end else begin : g_ang_down
      assign ang_w = Z_W'(in_if.heading >>> (HEADING_WIDTH - 19));
    end
  endgenerate

  // fold the angle into the right half plane
  always_comb begin
    z_fold_w = ang_w;
    flip_w   = 1'b0;
    if (ang_w > pdbv_pkg::HALF_PI_Q16) begin
      z_fold_w = ang_w - pdbv_pkg::PI_Q16;
      flip_w   = 1'b1;
    end else if (ang_w < -pdbv_pkg::HALF_PI_Q16) begin
      z_fold_w = ang_w + pdbv_pkg::PI_Q16;
      flip_w   = 1'b1;
    end
  end

  // rotation step operands
  assign sx_w   = x_r >>> cnt_r;
  assign sy_w   = y_r >>> cnt_r;
  assign atan_w = pdbv_pkg::atan_q16(cnt_r);

  // undo the fold and round cosine and sine to the trig fraction
  assign vx_w = flip_r ? -x_r : x_r;
  assign vy_w = flip_r ? -y_r : y_r;
  generate
    if (RND == 0) begin : g_no_rnd
      assign c_w = C_W'(vx_w);
      assign s_w = C_W'(vy_w);
    end else begin : g_rnd
      localparam logic signed [XY_W-1:0] RND_HALF = XY_W'(1) <<< (RND - 1);
      logic signed [XY_W-1:0] rx_w, ry_w;
      assign rx_w = (vx_w + RND_HALF) >>> RND;
      assign ry_w = (vy_w + RND_HALF) >>> RND;
      assign c_w  = C_W'(rx_w);
      assign s_w  = C_W'(ry_w);
    end
  endgenerate

  // shared multiplier: dx*c, dy*s, dy*c, dx*s
  assign mul_a_w = (cnt_r == STEP_W'(0) || cnt_r == STEP_W'(3)) ? dx_r : dy_r;
  assign mul_b_w = (cnt_r == STEP_W'(0) || cnt_r == STEP_W'(2)) ? c_r : s_r;
  assign prod_w  = mul_a_w * mul_b_w;

  // heading numerator and divider operand
  assign nt_w = NUM_W'(dh_r) <<< NT_SH;
  always_comb begin
    unique case (div_idx_r)
      DIV_FWD: div_num_w = nf_r;
      DIV_LAT: div_num_w = nl_r;
      default: div_num_w = nt_w;
    endcase
  end

  assign div_ctl.start  = (state_r == S_DIVGO);
  assign div_ctl.linear = (div_idx_r != DIV_TURN);

  pdbv_divider #(
    .NUM_W      (NUM_W),
    .LIN_SHIFT  (LIN_SHIFT),
    .POST_SHIFT (POST_SHIFT)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (div_ctl),
    .num    (div_num_w),
    .dt     (dt_r),
    .stat   (div_stat),
    .result (div_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept_w) begin
          cnt_nxt   = '0;
          state_nxt = have_prev_r ? S_CORDIC : S_DONE;
        end
      end
      S_CORDIC: begin
        cnt_nxt = STEP_W'(cnt_r + 1'b1);
        if (cnt_r == CORDIC_LAST) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cnt_nxt = STEP_W'(cnt_r + 1'b1);
        if (cnt_r == MUL_LAST) state_nxt = S_DIVGO;
      end
      S_DIVGO: state_nxt = S_DIVWAIT;
      S_DIVWAIT: begin
        if (div_stat.done) state_nxt = (div_idx_r == DIV_TURN) ? S_DONE : S_DIVGO;
      end
      S_DONE: begin
        if (out_take_w) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and stored sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_h_r    <= '0;
      prev_t_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (accept_w) begin
        have_prev_r <= 1'b1;
        prev_x_r    <= in_if.pos_x;
        prev_y_r    <= in_if.pos_y;
        prev_h_r    <= in_if.heading;
        prev_t_r    <= in_if.timestamp;
      end
      if (out_load_w) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept_w) begin
      dx_r       <= dx_w;
      dy_r       <= dy_w;
      dh_r       <= dh_w;
      dt_r       <= dt_w;
      x_r        <= pdbv_pkg::CORDIC_GAIN_Q30;
      y_r        <= '0;
      z_r        <= z_fold_w;
      flip_r     <= flip_w;
      div_idx_r  <= DIV_FWD;
      vv_r       <= have_prev_r;
      zi_r       <= have_prev_r && (dt_w == '0);
      res_fwd_r  <= '0;
      res_lat_r  <= '0;
      res_turn_r <= '0;
    end

    // rotate toward zero angle
    if (state_r == S_CORDIC) begin
      if (z_r >= 0) begin
        x_r <= x_r - sy_w;
        y_r <= y_r + sx_w;
        z_r <= z_r - atan_w;
      end else begin
        x_r <= x_r + sy_w;
        y_r <= y_r - sx_w;
        z_r <= z_r + atan_w;
      end
    end

    if (state_r == S_ROUND) begin
      c_r <= c_w;
      s_r <= s_w;
    end

    // accumulate the body frame numerators one product behind
    if (state_r == S_MUL) begin
      prod_r <= prod_w;
      if (cnt_r == STEP_W'(1)) nf_r <= NUM_W'(prod_r);
      if (cnt_r == STEP_W'(2)) nf_r <= nf_r + NUM_W'(prod_r);
      if (cnt_r == STEP_W'(3)) nl_r <= NUM_W'(prod_r);
      if (cnt_r == STEP_W'(4)) nl_r <= nl_r - NUM_W'(prod_r);
    end

    // store each quotient and advance to the next one
    if (state_r == S_DIVWAIT && div_stat.done) begin
      unique case (div_idx_r)
        DIV_FWD: res_fwd_r  <= div_res;
        DIV_LAT: res_lat_r  <= div_res;
        default: res_turn_r <= div_res;
      endcase
      div_idx_r <= (div_idx_r == DIV_FWD) ? DIV_LAT : DIV_TURN;
    end

    // hold the finished word for the consumer
    if (out_load_w) begin
      out_vv_r   <= vv_r;
      out_zi_r   <= zi_r;
      out_fwd_r  <= res_fwd_r;
      out_lat_r  <= res_lat_r;
      out_turn_r <= res_turn_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.velocity_valid = out_vv_r;
  assign out_if.vel_forward    = out_fwd_r;
  assign out_if.vel_lateral    = out_lat_r;
  assign out_if.vel_turn       = out_turn_r;
  assign out_if.zero_interval  = out_zi_r;

`ifndef NO_ASSERTIONS
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_stat.busy)
    else $error("divide started while the divider was busy");
  a_first_sample_short: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_w && !have_prev_r) |=> (state_r == S_DONE))
    else $error("first sample did not go straight to done");
  a_invalid_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vv_r) |->
      (out_fwd_r == '0 && out_lat_r == '0 && out_turn_r == '0 && !out_zi_r))
    else $error("first-sample word carries nonzero fields");
  a_done_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !div_stat.busy)
    else $error("word finished while the divider was still working");
`endif

endmodule

/* hw/rtl/pdbv_divider.sv */
// Serial restoring divider with truncation toward zero and 32-bit saturation.
module pdbv_divider #(
  parameter int NUM_W      = 60,
  parameter int LIN_SHIFT  = 8,
  parameter int POST_SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdbv_pkg::div_ctl_t            ctl,
  input  logic signed [NUM_W-1:0]       num,
  input  logic [pdbv_pkg::TIME_W-1:0]   dt,
  output pdbv_pkg::div_stat_t           stat,
  output logic [pdbv_pkg::VEL_W-1:0]    result
);

  localparam int Q_W   = pdbv_pkg::VEL_W;
  localparam int DV_W  = pdbv_pkg::TIME_W + LIN_SHIFT;
  localparam int HI_W  = NUM_W - Q_W;
  localparam int CMP_W = ((HI_W > DV_W) ? HI_W : DV_W) + 1;
  localparam int CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] Q_LAST = CNT_W'(Q_W - 1);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIN  = 3'b100
  } dstate_t;

  dstate_t          dstate_r, dstate_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             neg_r, zero_r, ovf_r, lin_r;
  logic [DV_W-1:0]  div_r, rem_r, rem_nxt;
  logic [Q_W-1:0]   qsh_r, qsh_nxt;

  logic             start_w, neg_w, ovf_w, ge_w, sat_w;
  logic [NUM_W-1:0] mag_w;
  logic [HI_W-1:0]  hi_w;
  logic [DV_W-1:0]  div_w;
  logic [DV_W:0]    trial_w;
  logic [Q_W-1:0]   mag32_w;

  // take the operands apart: sign, magnitude, divisor, early overflow
  assign start_w = ctl.start && (dstate_r == D_IDLE);
  assign neg_w   = num[NUM_W-1];
  assign mag_w   = neg_w ? NUM_W'(-num) : NUM_W'(num);
  assign hi_w    = mag_w[NUM_W-1:Q_W];
  assign div_w   = ctl.linear ? (DV_W'(dt) << LIN_SHIFT) : DV_W'(dt);
  assign ovf_w   = CMP_W'(hi_w) >= CMP_W'(div_w);

  // one quotient bit per cycle
  assign trial_w = {rem_r, qsh_r[Q_W-1]};
  assign ge_w    = trial_w >= {1'b0, div_r};
  assign rem_nxt = ge_w ? DV_W'(trial_w - {1'b0, div_r}) : trial_w[DV_W-1:0];
  assign qsh_nxt = {qsh_r[Q_W-2:0], ge_w};

  // sequence the divide
  always_comb begin
    dstate_nxt = dstate_r;
    cnt_nxt    = cnt_r;
    unique case (dstate_r)
      D_IDLE: begin
        if (start_w) begin
          cnt_nxt    = '0;
          dstate_nxt = ovf_w ? D_FIN : D_RUN;
        end
      end
      D_RUN: begin
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == Q_LAST) dstate_nxt = D_FIN;
      end
      D_FIN:   dstate_nxt = D_IDLE;
      default: dstate_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
      cnt_r    <= '0;
    end else begin
      dstate_r <= dstate_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // load operands, then shift remainder and quotient
  always_ff @(posedge clk) begin
    if (start_w) begin
      neg_r  <= neg_w;
      zero_r <= (mag_w == '0);
      ovf_r  <= ovf_w;
      lin_r  <= ctl.linear;
      div_r  <= div_w;
      rem_r  <= DV_W'(hi_w);
      qsh_r  <= mag_w[Q_W-1:0];
    end else if (dstate_r == D_RUN) begin
      rem_r  <= rem_nxt;
      qsh_r  <= qsh_nxt;
    end
  end

  // scale, saturate and restore the sign
  always_comb begin
    mag32_w = lin_r ? (qsh_r << POST_SHIFT) : qsh_r;
    sat_w   = ovf_r || (lin_r ? (|qsh_r[Q_W-1 -: POST_SHIFT+1]) : qsh_r[Q_W-1]);
    if (zero_r) begin
      result = '0;
    end else if (sat_w) begin
      result = neg_r ? pdbv_pkg::VEL_MIN : pdbv_pkg::VEL_MAX;
    end else begin
      result = neg_r ? Q_W'(-mag32_w) : mag32_w;
    end
  end

  assign stat.busy = (dstate_r != D_IDLE);
  assign stat.done = (dstate_r == D_FIN);

`ifndef NO_ASSERTIONS
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_w |=> (dstate_r != D_IDLE))
    else $error("divider did not leave idle after start");
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (dstate_r == D_RUN && cnt_r == Q_LAST) |=> (dstate_r == D_FIN))
    else $error("divider ran past the last quotient bit");
  a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
    (dstate_r == D_FIN) |=> (dstate_r == D_IDLE))
    else $error("divider held its result for more than one cycle");
`endif

endmodule
